@@ rtl/core/sttrk_pkg.sv @@
// ----------------------------------------------------------------------------
// sttrk_pkg
// Shared types and constants for the scratchpad temperature tracker: request
// and result payloads, register map and CRC unit control.
// ----------------------------------------------------------------------------
package sttrk_pkg;

    // sizing
    localparam int SENSOR_COUNT      = 8;
    localparam int SCRATCHPAD_LENGTH = 9;
    localparam int SENS_W            = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam int SCAN_W            = $clog2(SENSOR_COUNT + 1);
    localparam int POS_W             = $clog2(SCRATCHPAD_LENGTH + 1);
    localparam int TEMP_W            = 16;

    // crc-8, reflected dallas/maxim polynomial
    localparam logic [7:0] CRC_POLY  = 8'h8C;
    localparam int         CRC_BITS  = 8;
    localparam int         CRC_CNT_W = $clog2(CRC_BITS);

    // request command codes
    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_FAILURE = 1'b1;

    // apb register map, one 32-bit word per register
    localparam int             PADDR_W    = 4;
    localparam int             PDATA_W    = 32;
    localparam int             REG_IDX_W  = 2;
    localparam logic [REG_IDX_W-1:0] REG_MIN_VALID = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAX_VALID = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_OVERTEMP  = 2'd2;

    localparam logic signed [TEMP_W-1:0] MIN_VALID_RST = -16'sd880;
    localparam logic signed [TEMP_W-1:0] MAX_VALID_RST = 16'sd2000;
    localparam logic signed [TEMP_W-1:0] OVERTEMP_RST  = 16'sd960;

    typedef logic signed [TEMP_W-1:0] temp_t;

    // request payload
    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } in_t;

    // result payload
    typedef struct packed {
        logic [2:0]               sensor_number;
        logic signed [TEMP_W-1:0] temperature;
        logic                     temperature_ok;
        logic signed [TEMP_W-1:0] hottest;
        logic                     hottest_ok;
        logic                     overheat;
    } out_t;

    // crc unit control and status
    typedef struct packed {
        logic start;
        logic clear;
    } crc_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } crc_stat_t;

endpackage

@@ rtl/core/sttrk_crc8.sv @@
// ----------------------------------------------------------------------------
// sttrk_crc8
// Bit-serial reflected CRC-8 unit: folds one byte into the running remainder,
// one bit per cycle, least significant bit first.
// ----------------------------------------------------------------------------
module sttrk_crc8 (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sttrk_pkg::crc_ctrl_t  ctrl,
    input  logic [7:0]            data_byte,
    output sttrk_pkg::crc_stat_t  stat,
    output logic [7:0]            crc
);
    import sttrk_pkg::*;

    logic [7:0]           crc_reg;
    logic [7:0]           shift_reg;
    logic [CRC_CNT_W-1:0] bit_cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic                 fb;

    // feedback bit of the current step
    assign fb = crc_reg[0] ^ shift_reg[0];

    // one polynomial step per cycle while busy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg     <= '0;
            shift_reg   <= '0;
            bit_cnt_reg <= '0;
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            // done pulses with the eighth step
            done_reg <= busy_reg && !ctrl.start &&
                        (bit_cnt_reg == CRC_CNT_W'(CRC_BITS - 1));
            if (ctrl.clear) begin
                crc_reg <= '0;
            end
            if (ctrl.start) begin
                shift_reg   <= data_byte;
                bit_cnt_reg <= '0;
                busy_reg    <= 1'b1;
            end else if (busy_reg) begin
                crc_reg     <= (crc_reg >> 1) ^ (fb ? CRC_POLY : 8'h00);
                shift_reg   <= shift_reg >> 1;
                bit_cnt_reg <= bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == CRC_CNT_W'(CRC_BITS - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign crc       = crc_reg;

endmodule

@@ rtl/core/scratchpad_temperature_tracker_top.sv @@
// ----------------------------------------------------------------------------
// scratchpad_temperature_tracker_top
// Collects 1-Wire scratchpad bytes, checks CRC-8 and bounds of the reading,
// keeps one reading per sensor and reports the hottest valid one.
// ----------------------------------------------------------------------------
//  channel   ports                      direction  payload
//  request   s_valid s_ready s_data     in         sttrk_pkg::in_t
//  result    m_valid m_ready m_data     out        sttrk_pkg::out_t
//  config    psel penable pwrite paddr  in/out     32-bit registers at 0, 4, 8
//
//  A scratchpad byte is accepted, folded in by the bit-serial CRC unit, which
//  sets the rate, and closed when the sequencer sees its done flag. The last
//  byte adds check, store write and a scan of the 8 stored readings before the
//  result register; a failure request skips CRC and check. Reset clears
//  pointer, byte count, CRC and valid flags at once; no clearing pass. A
//  waiting result stalls the next completion, and byte intake from then on.
// ----------------------------------------------------------------------------
module scratchpad_temperature_tracker_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  sttrk_pkg::in_t                    s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output sttrk_pkg::out_t                   m_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sttrk_pkg::PADDR_W-1:0]     paddr,
    input  logic [sttrk_pkg::PDATA_W-1:0]     pwdata,
    output logic [sttrk_pkg::PDATA_W-1:0]     prdata,
    output logic                              pready
);
    import sttrk_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CRC,
        ST_CHECK,
        ST_WRITE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t                state_reg;
    temp_t                 min_valid_reg;
    temp_t                 max_valid_reg;
    temp_t                 overtemp_reg;
    logic [SENS_W-1:0]     ptr_reg;
    logic [SENS_W-1:0]     num_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [7:0]            low_reg;
    logic [7:0]            high_reg;
    temp_t                 temp_reg;
    logic                  ok_reg;
    logic [SENSOR_COUNT-1:0] flags_reg;
    logic [SCAN_W-1:0]     scan_cnt_reg;
    logic                  cmp_en_reg;
    logic                  rd_flag_reg;
    temp_t                 rd_temp_reg;
    temp_t                 best_reg;
    logic                  any_reg;
    logic                  hot_reg;
    logic                  m_valid_reg;
    out_t                  m_data_reg;
    temp_t                 store [SENSOR_COUNT];

    logic                  s_fire;
    logic                  cfg_write;
    logic [REG_IDX_W-1:0]  reg_idx;
    temp_t                 raw;
    logic [SENS_W-1:0]     scan_idx;
    logic                  scan_issue;
    logic                  out_free;
    crc_ctrl_t             crc_ctrl;
    crc_stat_t             crc_stat;
    logic [7:0]            crc;

    // handshake and decode
    assign s_ready    = (state_reg == ST_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite;
    assign reg_idx    = paddr[REG_IDX_W+1:2];
    assign raw        = {high_reg, low_reg};
    assign scan_idx   = scan_cnt_reg[SENS_W-1:0];
    assign scan_issue = (state_reg == ST_SCAN) && (scan_cnt_reg < SCAN_W'(SENSOR_COUNT));
    assign out_free   = !m_valid_reg || m_ready;

    // crc unit control
    assign crc_ctrl.start = s_fire && (s_data.cmd == CMD_BYTE);
    assign crc_ctrl.clear = (state_reg == ST_WRITE);

    sttrk_crc8 u_crc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (crc_ctrl),
        .data_byte (s_data.data_byte),
        .stat      (crc_stat),
        .crc       (crc)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_valid_reg <= MIN_VALID_RST;
            max_valid_reg <= MAX_VALID_RST;
            overtemp_reg  <= OVERTEMP_RST;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_MIN_VALID: min_valid_reg <= pwdata[TEMP_W-1:0];
                REG_MAX_VALID: max_valid_reg <= pwdata[TEMP_W-1:0];
                REG_OVERTEMP:  overtemp_reg  <= pwdata[TEMP_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_idx)
            REG_MIN_VALID: prdata = PDATA_W'(min_valid_reg);
            REG_MAX_VALID: prdata = PDATA_W'(max_valid_reg);
            REG_OVERTEMP:  prdata = PDATA_W'(overtemp_reg);
            default:       prdata = '0;
        endcase
    end

    // reading store: write after check, one read per scan cycle
    always_ff @(posedge aclk) begin
        if (state_reg == ST_WRITE && ok_reg) begin
            store[ptr_reg] <= temp_reg;
        end
        rd_temp_reg <= store[scan_idx];
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ptr_reg      <= '0;
            num_reg      <= '0;
            pos_reg      <= '0;
            low_reg      <= '0;
            high_reg     <= '0;
            temp_reg     <= '0;
            ok_reg       <= 1'b0;
            flags_reg    <= '0;
            scan_cnt_reg <= '0;
            cmp_en_reg   <= 1'b0;
            rd_flag_reg  <= 1'b0;
            best_reg     <= '0;
            any_reg      <= 1'b0;
            hot_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            // result taken while no new one is loaded
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        if (s_data.cmd == CMD_FAILURE) begin
                            ok_reg    <= 1'b0;
                            temp_reg  <= '0;
                            state_reg <= ST_WRITE;
                        end else begin
                            if (pos_reg == POS_W'(0)) begin
                                low_reg <= s_data.data_byte;
                            end
                            if (pos_reg == POS_W'(1)) begin
                                high_reg <= s_data.data_byte;
                            end
                            pos_reg   <= pos_reg + 1'b1;
                            state_reg <= ST_CRC;
                        end
                    end
                end
                ST_CRC: begin
                    if (crc_stat.done) begin
                        if (pos_reg == POS_W'(SCRATCHPAD_LENGTH)) begin
                            state_reg <= ST_CHECK;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_CHECK: begin
                    // crc residue zero and reading inside bounds
                    if (crc == 8'h00 && raw >= min_valid_reg && raw <= max_valid_reg) begin
                        ok_reg   <= 1'b1;
                        temp_reg <= raw;
                    end else begin
                        ok_reg   <= 1'b0;
                        temp_reg <= '0;
                    end
                    state_reg <= ST_WRITE;
                end
                ST_WRITE: begin
                    flags_reg[ptr_reg] <= ok_reg;
                    num_reg            <= ptr_reg;
                    if (ptr_reg == SENS_W'(SENSOR_COUNT - 1)) begin
                        ptr_reg <= '0;
                    end else begin
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                    pos_reg      <= '0;
                    scan_cnt_reg <= '0;
                    cmp_en_reg   <= 1'b0;
                    best_reg     <= '0;
                    any_reg      <= 1'b0;
                    hot_reg      <= 1'b0;
                    state_reg    <= ST_SCAN;
                end
                ST_SCAN: begin
                    // read one entry, compare the one read last cycle
                    rd_flag_reg  <= flags_reg[scan_idx];
                    cmp_en_reg   <= scan_issue;
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    if (cmp_en_reg && rd_flag_reg) begin
                        if (!any_reg || rd_temp_reg > best_reg) begin
                            best_reg <= rd_temp_reg;
                        end
                        any_reg <= 1'b1;
                        if (rd_temp_reg > overtemp_reg) begin
                            hot_reg <= 1'b1;
                        end
                    end
                    if (scan_cnt_reg == SCAN_W'(SENSOR_COUNT)) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // load result register once it is free
                    if (out_free) begin
                        m_data_reg.sensor_number  <= 3'(num_reg);
                        m_data_reg.temperature    <= temp_reg;
                        m_data_reg.temperature_ok <= ok_reg;
                        m_data_reg.hottest        <= best_reg;
                        m_data_reg.hottest_ok     <= any_reg;
                        m_data_reg.overheat       <= hot_reg;
                        m_valid_reg               <= 1'b1;
                        state_reg                 <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
